>>> hw/rtl/granular_chain_verlet_step_macros.svh
// Assertion macros shared by the chain step design.
`ifndef GRANULAR_CHAIN_VERLET_STEP_MACROS_SVH
`define GRANULAR_CHAIN_VERLET_STEP_MACROS_SVH

// Condition holds in the same cycle as the trigger.
`define GCVS_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Condition holds in the cycle after the trigger.
`define GCVS_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/gcvs_pkg.sv
package gcvs_pkg;

  localparam int unsigned MAX_PARTICLES_DEF = 64;

  localparam logic signed [63:0] Q_MAX  = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] Q_MIN  = 64'sh8000_0000_0000_0000;
  localparam logic signed [63:0] Q_HALF = 64'sh0000_0000_8000_0000;

  // Operation codes of an input request.
  localparam logic [1:0] OP_LOAD    = 2'd0;
  localparam logic [1:0] OP_ADVANCE = 2'd1;
  localparam logic [1:0] OP_READ    = 2'd2;
  localparam logic [1:0] OP_UNUSED  = 2'd3;

  // Configuration register indexes.
  localparam logic [2:0] REG_COUNT     = 3'd0;
  localparam logic [2:0] REG_DT        = 3'd1;
  localparam logic [2:0] REG_DIAMETER  = 3'd2;
  localparam logic [2:0] REG_STIFFNESS = 3'd3;
  localparam logic [2:0] REG_LIM_OV    = 3'd4;
  localparam logic [2:0] REG_LIM_F     = 3'd5;
  localparam logic [2:0] REG_SLOPE     = 3'd6;
  localparam logic [2:0] REG_INV_MASS  = 3'd7;

  typedef enum logic [3:0] {
    ST_IDLE, ST_RDWAIT, ST_RDEMIT, ST_FETCH, ST_FETCH2, ST_FETCH3,
    ST_ISSUE, ST_WAIT, ST_WRITE
  } state_t;

  // Steps of one particle update.
  typedef enum logic [3:0] {
    C_ADT, C_VDT, C_ADT2, C_HX, C_HV, C_PAIR, C_SQRT, C_OVS, C_KF, C_PL,
    C_AN, C_ANDT, C_HVN
  } step_t;

  function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
    logic signed [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) return s[64] ? Q_MIN : Q_MAX;
    return s[63:0];
  endfunction

  function automatic logic signed [63:0] sat_sub(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
    logic signed [64:0] s;
    s = {a[63], a} - {b[63], b};
    if (s[64] != s[63]) return s[64] ? Q_MIN : Q_MAX;
    return s[63:0];
  endfunction

  function automatic logic signed [63:0] sat_abs(input logic signed [63:0] a);
    if (a == Q_MIN) return Q_MAX;
    return a[63] ? -a : a;
  endfunction

endpackage

>>> hw/rtl/gcvs_qmul.sv
// Saturating Q31.32 multiplier: four 32x32 partial products, one a cycle.
module gcvs_qmul
  import gcvs_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [63:0] a,
  input  logic signed [63:0] b,
  output logic               done,
  output logic signed [63:0] res
);

  logic [63:0]  ma;
  logic [63:0]  mb;
  logic         neg;
  logic [127:0] acc;
  logic [2:0]   cnt;
  logic         busy;
  logic [31:0]  pa;
  logic [31:0]  pb;
  logic [63:0]  pp;
  logic [127:0] pp_sh;
  logic [63:0]  mag;
  logic signed [63:0] fin;

  // Partial product for the current pair of halves.
  always_comb begin
    pa = cnt[0] ? ma[63:32] : ma[31:0];
    pb = cnt[1] ? mb[63:32] : mb[31:0];
    pp = 64'(pa) * 64'(pb);
    case (cnt[1:0])
      2'd0:    pp_sh = {64'b0, pp};
      2'd3:    pp_sh = {pp, 64'b0};
      default: pp_sh = {32'b0, pp, 32'b0};
    endcase
  end

  // Drop 32 fraction bits, saturate, restore the sign.
  always_comb begin
    mag = (acc[127:96] != 32'b0) ? 64'hFFFF_FFFF_FFFF_FFFF : acc[95:32];
    if (!neg) fin = mag[63] ? Q_MAX : $signed(mag);
    else if (mag[63]) fin = Q_MIN;
    else fin = -$signed(mag);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= 3'd0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 3'd0;
      end else if (busy) begin
        if (cnt == 3'd4) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
        cnt <= cnt + 3'd1;
      end
    end
  end

  // Operand and accumulator registers.
  always_ff @(posedge clk) begin
    if (start) begin
      ma  <= a[63] ? 64'(-a) : 64'(a);
      mb  <= b[63] ? 64'(-b) : 64'(b);
      neg <= a[63] ^ b[63];
      acc <= '0;
    end else if (busy) begin
      if (cnt == 3'd4) res <= fin;
      else acc <= acc + pp_sh;
    end
  end

endmodule

>>> hw/rtl/gcvs_sqrt.sv
// Bit-serial square root of x * 2^32, one result bit a cycle.
module gcvs_sqrt (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [63:0] x,
  output logic               done,
  output logic signed [63:0] root
);

  logic [95:0] rad;
  logic [50:0] rem;
  logic [47:0] rt;
  logic [5:0]  cnt;
  logic        busy;
  logic [50:0] rem_sh;
  logic [50:0] trial;
  logic        take;

  // One restoring step of the digit recurrence.
  always_comb begin
    rem_sh = {rem[48:0], rad[95:94]};
    trial  = {1'b0, rt, 2'b01};
    take   = rem_sh >= trial;
  end

  assign root = $signed({16'b0, rt});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= 6'd0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 6'd0;
      end else if (busy) begin
        if (cnt == 6'd47) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
        cnt <= cnt + 6'd1;
      end
    end
  end

  // Nonpositive inputs feed a zero radicand and give zero.
  always_ff @(posedge clk) begin
    if (start) begin
      rad <= x[63] ? 96'b0 : {1'b0, x[62:0], 32'b0};
      rem <= '0;
      rt  <= '0;
    end else if (busy) begin
      rad <= {rad[93:0], 2'b00};
      rem <= take ? rem_sh - trial : rem_sh;
      rt  <= {rt[46:0], take};
    end
  end

endmodule

>>> hw/rtl/granular_chain_verlet_step.sv
// Channel  Dir  Request contents
// s_*      in   operation, particle_index, position, velocity
// m_*      out  result_index, result_position, result_velocity, net_force; tlast
// cfg_*    in   register index and write data
//
// A load is written as it is accepted; a read passes through ST_RDWAIT and ST_RDEMIT to its result.
// The time an advance spends on each particle is set by the shared multiplier
// (eight to twelve products) and the square root used once per contact in the
// elastic range.
// Reset is synchronous; the particle memories are not cleared and hold
// whatever was loaded. A stalled result holds the walk until it is taken.
`include "granular_chain_verlet_step_macros.svh"

module granular_chain_verlet_step
  import gcvs_pkg::*;
#(
  parameter int unsigned MaxParticles = MAX_PARTICLES_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // operation [1:0], particle_index [7:2], position [71:8], velocity [135:72]
  input  logic [135:0] s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // result_index [5:0], result_position [69:6], result_velocity [133:70],
  // net_force [197:134], zero [199:198]
  output logic [199:0] m_tdata,
  output logic         m_tlast,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [2:0]   cfg_index,
  input  logic [63:0]  cfg_data
);

  localparam int unsigned AW = $clog2(MaxParticles);
  localparam int unsigned CW = $clog2(MaxParticles + 1);

  state_t state, state_next;
  step_t  step, step_next;

  // Configuration registers.
  logic [6:0]  cnt_cfg;
  logic [62:0] dt_cfg, cd_cfg, k_cfg, lim_ov_cfg, lim_f_cfg, slope_cfg, inv_m_cfg;

  // Particle memories.
  logic signed [63:0] pos_mem [MaxParticles];
  logic signed [63:0] vel_mem [MaxParticles];
  logic signed [63:0] acc_mem [MaxParticles];
  logic signed [63:0] pos_rd, vel_rd, acc_rd;
  logic [AW-1:0]      rd_addr, wr_addr;
  logic               wr_en;
  logic signed [63:0] wr_pos, wr_vel, wr_acc;

  // Walk and datapath registers.
  logic [AW-1:0]      walk;
  logic               side;
  logic [5:0]         rd_idx;
  logic               rd_ok;
  logic signed [63:0] x_r, v_r, a_r, xnext, prev_xn;
  logic signed [63:0] adt, tmp, xn, vh, vn, an, f_acc, ov, sroot;

  // Output register.
  logic               out_valid;
  logic [5:0]         out_idx;
  logic signed [63:0] out_pos, out_vel, out_frc;
  logic               out_last;

  // Arithmetic units.
  logic               mul_start, mul_done, sq_start, sq_done;
  logic signed [63:0] mul_a, mul_b, mul_res, sq_res;

  // Decoded input fields.
  logic [1:0]         in_op;
  logic [5:0]         in_idx;
  logic signed [63:0] in_pos, in_vel;
  logic               in_acc, in_range;

  logic [CW-1:0]      n_len;
  logic [CW-1:0]      walk_inc;
  logic               has_right, last_p, out_free, unit_done;
  logic signed [63:0] xa, xb, gap, cdv, overlap, pf, f_new;
  logic               contact, more_pair;

  assign in_op    = s_tdata[1:0];
  assign in_idx   = s_tdata[7:2];
  assign in_pos   = $signed(s_tdata[71:8]);
  assign in_vel   = $signed(s_tdata[135:72]);
  assign in_acc   = s_tvalid && s_tready;
  assign in_range = 7'(in_idx) < 7'(MaxParticles);

  assign cfg_ready = 1'b1;
  assign m_tvalid  = out_valid;
  assign m_tlast   = out_last;
  assign m_tdata   = {2'b00, out_frc, out_vel, out_pos, out_idx};
  assign out_free  = !out_valid || m_tready;

  // Chain length clamped to at least two and at most the memory depth.
  always_comb begin
    if (cnt_cfg < 7'd2) n_len = CW'(2);
    else if (cnt_cfg > 7'(MaxParticles)) n_len = CW'(MaxParticles);
    else n_len = cnt_cfg[CW-1:0];
  end

  assign walk_inc  = CW'(walk) + CW'(1);
  assign has_right = walk_inc < n_len;
  assign last_p    = walk_inc == n_len;
  assign unit_done = (step == C_SQRT) ? sq_done : mul_done;

  // Pair geometry for the side being worked on.
  always_comb begin
    xa      = side ? x_r : prev_xn;
    xb      = side ? xnext : x_r;
    gap     = sat_abs(sat_sub(xa, xb));
    cdv     = $signed({1'b0, cd_cfg});
    contact = gap <= cdv;
    overlap = cdv - gap;
  end

  // Pair force on completion and the running net force.
  always_comb begin
    if (state == ST_WAIT && step == C_KF) pf = mul_res;
    else if (state == ST_WAIT && step == C_PL) pf = sat_add($signed({1'b0, lim_f_cfg}), mul_res);
    else pf = '0;
    f_new     = side ? sat_sub(f_acc, pf) : pf;
    more_pair = !side && has_right;
  end

  // Next state and next step.
  always_comb begin
    state_next = state;
    step_next  = step;
    case (state)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_op == OP_READ) state_next = ST_RDWAIT;
          else if (in_op == OP_ADVANCE) state_next = ST_FETCH;
        end
      end
      ST_RDWAIT: state_next = ST_RDEMIT;
      ST_RDEMIT: if (out_free) state_next = ST_IDLE;
      ST_FETCH:  state_next = ST_FETCH2;
      ST_FETCH2: state_next = ST_FETCH3;
      ST_FETCH3: begin
        state_next = ST_ISSUE;
        step_next  = C_ADT;
      end
      ST_ISSUE: begin
        if (step == C_PAIR) begin
          if (!contact) step_next = more_pair ? C_PAIR : C_AN;
          else if (overlap <= $signed({1'b0, lim_ov_cfg})) step_next = C_SQRT;
          else step_next = C_PL;
        end else begin
          state_next = ST_WAIT;
        end
      end
      ST_WAIT: begin
        if (unit_done) begin
          state_next = ST_ISSUE;
          case (step)
            C_ADT:  step_next = C_VDT;
            C_VDT:  step_next = C_ADT2;
            C_ADT2: step_next = C_HX;
            C_HX:   step_next = C_HV;
            C_HV:   step_next = C_PAIR;
            C_SQRT: step_next = C_OVS;
            C_OVS:  step_next = C_KF;
            C_KF:   step_next = more_pair ? C_PAIR : C_AN;
            C_PL:   step_next = more_pair ? C_PAIR : C_AN;
            C_AN:   step_next = C_ANDT;
            C_ANDT: step_next = C_HVN;
            C_HVN:  state_next = ST_WRITE;
            default: step_next = C_ADT;
          endcase
        end
      end
      ST_WRITE: if (out_free) state_next = last_p ? ST_IDLE : ST_FETCH;
      default: state_next = ST_IDLE;
    endcase
  end

  // Handshake, memory and unit controls.
  always_comb begin
    s_tready  = state == ST_IDLE;
    mul_start = state == ST_ISSUE && step != C_PAIR && step != C_SQRT;
    sq_start  = state == ST_ISSUE && step == C_SQRT;
    mul_a     = tmp;
    mul_b     = $signed({1'b0, dt_cfg});
    case (step)
      C_ADT:  mul_a = a_r;
      C_VDT:  mul_a = v_r;
      C_ADT2: mul_a = adt;
      C_HX:   mul_a = Q_HALF;
      C_HV: begin
        mul_a = Q_HALF;
        mul_b = adt;
      end
      C_OVS: begin
        mul_a = ov;
        mul_b = sroot;
      end
      C_KF: begin
        mul_a = $signed({1'b0, k_cfg});
        mul_b = tmp;
      end
      C_PL: begin
        mul_a = $signed({1'b0, slope_cfg});
        mul_b = ov - $signed({1'b0, lim_ov_cfg});
      end
      C_AN: begin
        mul_a = f_acc;
        mul_b = $signed({1'b0, inv_m_cfg});
      end
      C_ANDT: mul_a = an;
      C_HVN:  mul_a = Q_HALF;
      default: mul_a = tmp;
    endcase
    if (step == C_HX || step == C_HVN) mul_b = tmp;

    case (state)
      ST_FETCH2: rd_addr = AW'(walk_inc);
      ST_IDLE:   rd_addr = in_idx[AW-1:0];
      default:   rd_addr = walk;
    endcase

    wr_en   = 1'b0;
    wr_addr = walk;
    wr_pos  = xn;
    wr_vel  = vn;
    wr_acc  = an;
    if (state == ST_IDLE && in_acc && in_op == OP_LOAD && in_range) begin
      wr_en   = 1'b1;
      wr_addr = in_idx[AW-1:0];
      wr_pos  = in_pos;
      wr_vel  = in_vel;
      wr_acc  = '0;
    end else if (state == ST_WRITE && out_free) begin
      wr_en = 1'b1;
    end
  end

  // Particle memories with registered reads.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      pos_mem[wr_addr] <= wr_pos;
      vel_mem[wr_addr] <= wr_vel;
      acc_mem[wr_addr] <= wr_acc;
    end
    pos_rd <= pos_mem[rd_addr];
    vel_rd <= vel_mem[rd_addr];
    acc_rd <= acc_mem[rd_addr];
  end

  // Control state and configuration.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      step       <= C_ADT;
      walk       <= '0;
      out_valid  <= 1'b0;
      cnt_cfg    <= 7'd2;
      dt_cfg     <= '0;
      cd_cfg     <= '0;
      k_cfg      <= '0;
      lim_ov_cfg <= '0;
      lim_f_cfg  <= '0;
      slope_cfg  <= '0;
      inv_m_cfg  <= '0;
    end else begin
      state <= state_next;
      step  <= step_next;
      if (state == ST_WRITE && out_free) walk <= last_p ? '0 : AW'(walk_inc);
      if ((state == ST_WRITE || state == ST_RDEMIT) && out_free) out_valid <= 1'b1;
      else if (m_tready) out_valid <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_COUNT:     cnt_cfg    <= cfg_data[6:0];
          REG_DT:        dt_cfg     <= cfg_data[62:0];
          REG_DIAMETER:  cd_cfg     <= cfg_data[62:0];
          REG_STIFFNESS: k_cfg      <= cfg_data[62:0];
          REG_LIM_OV:    lim_ov_cfg <= cfg_data[62:0];
          REG_LIM_F:     lim_f_cfg  <= cfg_data[62:0];
          REG_SLOPE:     slope_cfg  <= cfg_data[62:0];
          REG_INV_MASS:  inv_m_cfg  <= cfg_data[62:0];
          default: ;
        endcase
      end
    end
  end

  // Datapath registers of the particle update.
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        rd_idx <= in_idx;
        rd_ok  <= in_range;
      end
      ST_RDWAIT: begin
        x_r <= rd_ok ? pos_rd : '0;
        v_r <= rd_ok ? vel_rd : '0;
      end
      ST_FETCH2: begin
        x_r <= pos_rd;
        v_r <= vel_rd;
        a_r <= acc_rd;
      end
      ST_FETCH3: xnext <= pos_rd;
      ST_ISSUE: begin
        if (step == C_PAIR) begin
          ov <= overlap;
          if (!contact) begin
            f_acc <= f_new;
            if (more_pair) side <= 1'b1;
          end
        end
      end
      ST_WAIT: begin
        if (unit_done) begin
          case (step)
            C_ADT:  adt <= mul_res;
            C_VDT:  xn  <= sat_add(x_r, mul_res);
            C_ADT2: tmp <= mul_res;
            C_HX:   xn  <= sat_add(xn, mul_res);
            C_HV: begin
              vh    <= sat_add(v_r, mul_res);
              side  <= walk == '0;
              f_acc <= '0;
            end
            C_SQRT: sroot <= sq_res;
            C_OVS:  tmp   <= mul_res;
            C_KF, C_PL: begin
              f_acc <= f_new;
              if (more_pair) side <= 1'b1;
            end
            C_AN:   an  <= mul_res;
            C_ANDT: tmp <= mul_res;
            C_HVN:  vn  <= sat_add(vh, mul_res);
            default: ;
          endcase
        end
      end
      default: ;
    endcase
    if (state == ST_WRITE && out_free) prev_xn <= xn;
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (state == ST_RDEMIT && out_free) begin
      out_idx  <= rd_idx;
      out_pos  <= x_r;
      out_vel  <= v_r;
      out_frc  <= '0;
      out_last <= 1'b1;
    end else if (state == ST_WRITE && out_free) begin
      out_idx  <= 6'(walk);
      out_pos  <= xn;
      out_vel  <= vn;
      out_frc  <= f_acc;
      out_last <= last_p;
    end
  end

  gcvs_qmul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .res   (mul_res)
  );

  gcvs_sqrt u_sqrt (
    .clk   (clk),
    .rst   (rst),
    .start (sq_start),
    .x     (ov),
    .done  (sq_done),
    .root  (sq_res)
  );

  // Unit results only land while the sequencer waits for them.
  `GCVS_ASSERT_SAME(a_mul_done_wait, clk, rst, mul_done, state == ST_WAIT, "multiply done outside wait")
  // A committed particle always produces a result request.
  `GCVS_ASSERT_NEXT(a_write_emits, clk, rst, state == ST_WRITE && out_free, m_tvalid, "particle result lost")
  // The walk is back at zero whenever the block is idle.
  `GCVS_ASSERT_SAME(a_walk_idle, clk, rst, state == ST_IDLE, walk == '0, "walk index not reset")

endmodule
